/* rtl/tte_pkg.sv */
// Shared constants, result types and start-pattern lookup for the title extractor.
package tte_pkg;

  // Start pattern: length used and the fixed text it is taken from
  localparam int unsigned PATTERN_LEN      = 54;
  localparam int unsigned PATTERN_TEXT_LEN = 54;
  localparam logic [PATTERN_TEXT_LEN*8-1:0] PATTERN_TEXT =
    "<h5><a rel=\"nofollow\" target=\"_blank\" href=\"/o.php?ux=";

  // Bytes-seen counter, saturating at PATTERN_LEN
  localparam int unsigned FILL_W = $clog2(PATTERN_LEN + 1);

  // Text markers
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_GT  = 8'h3E;
  localparam logic [7:0] CHAR_LT  = 8'h3C;

  // Scan phases
  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_SEEK  = 2'd2;
  localparam logic [1:0] PH_TITLE = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_CHAR  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_NO_GT = 3'd2;
  localparam logic [2:0] KIND_NO_LT = 3'd3;
  localparam logic [2:0] KIND_DONE  = 3'd4;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Output queue depth (two results may be written per transaction)
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Output tdata width: 27 payload bits padded to whole bytes
  localparam int unsigned RES_DATA_W = 27;
  localparam int unsigned OUT_DATA_W = ((RES_DATA_W + 7) / 8) * 8;

  typedef struct packed {
    logic        last;
    logic [15:0] number;
    logic [7:0]  title_char;
    logic [2:0]  kind;
  } res_t;

  // Results written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    res_t       e0;
    res_t       e1;
  } push_t;

  // Pattern byte at position idx; zero past the end of the text
  function automatic logic [7:0] pattern_byte(input int unsigned idx);
    logic [7:0] b;
    b = CHAR_NUL;
    if (idx < PATTERN_TEXT_LEN) begin
      b = PATTERN_TEXT[(PATTERN_TEXT_LEN - 1 - idx) * 8 +: 8];
    end
    return b;
  endfunction

endpackage

/* rtl/tte_cell.sv */
// One byte of the sliding match window with its pattern compare.
module tte_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] pattern_i,
  input  logic [7:0] data_i,
  output logic [7:0] data_o,
  output logic       match_o
);

  logic [7:0] byte_q;

  // Byte moves in from the neighbour on each shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (shift_i) begin
      byte_q <= data_i;
    end
  end

  // Compare on the incoming byte: match of the window after this shift
  assign match_o = (data_i == pattern_i);
  assign data_o  = byte_q;

endmodule

/* rtl/tte_outq.sv */
// Small result queue: takes up to two results a cycle, hands out one.
module tte_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tte_pkg::push_t        push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output tte_pkg::res_t         res_o
);
  import tte_pkg::*;

  res_t             mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop     = (cnt_q != '0) && ready_i;
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign room_o  = (cnt_q <= OQ_CW'(OQ_DEPTH - 2));

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q + OQ_AW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + OQ_AW'(pop);
    cnt_d    = cnt_q + OQ_CW'(push_i.cnt) - OQ_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage: first result at the write pointer, second just after it
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + OQ_AW'(1)] <= push_i.e1;
    end
  end

endmodule

/* rtl/tagged_title_extractor_core.sv */
// Top level: match-window cell chain, scan control and result queue.
// Results are registered in the output queue before they are offered on m_axis.
// Throughput: one byte per cycle; a zero byte after a match yields two results,
// absorbed by the four-entry queue, so input stalls only under output back-pressure.
// The 54-cell window compare decides the pattern match in the accepting cycle.
// Reset (rst_ni low, asynchronous): hunting phase, empty window, count zero.
module tagged_title_extractor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] kind, [10:3] title_char, [26:11] result_number
  output logic        m_axis_tlast    // last_of_run
);
  import tte_pkg::*;

  logic [1:0]             phase_q, phase_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [15:0]            count_q, count_d;
  logic [7:0]             win [PATTERN_LEN];
  logic [PATTERN_LEN-1:0] cell_match;
  logic                   in_fire;
  logic                   shift;
  logic                   room;
  logic [7:0]             b;
  logic [15:0]            num_now;
  push_t                  push;
  res_t                   res;

  assign b             = s_axis_tdata;
  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid && room;
  assign shift         = in_fire && (phase_q == PH_HUNT) && (b != CHAR_NUL);
  assign num_now       = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 16'd1;

  // Window chain: newest byte enters the last cell, bytes move down a cell
  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    logic [7:0] cell_in;
    if (i == PATTERN_LEN - 1) begin : g_head
      assign cell_in = b;
    end else begin : g_body
      assign cell_in = win[i + 1];
    end
    tte_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .pattern_i(pattern_byte(i)),
      .data_i   (cell_in),
      .data_o   (win[i]),
      .match_o  (cell_match[i])
    );
  end

  // Scan control and result generation
  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    count_d  = count_q;
    push     = '0;
    if (in_fire) begin
      if (b == CHAR_NUL) begin
        // End of text: optional error, then done; clear for the next text
        if (phase_q == PH_SKIP || phase_q == PH_SEEK) begin
          push.cnt = 2'd2;
          push.e0  = '{last: 1'b0, number: num_now, title_char: 8'h00, kind: KIND_NO_GT};
          push.e1  = '{last: 1'b1, number: count_q, title_char: 8'h00, kind: KIND_DONE};
        end else if (phase_q == PH_TITLE) begin
          push.cnt = 2'd2;
          push.e0  = '{last: 1'b0, number: num_now, title_char: 8'h00, kind: KIND_NO_LT};
          push.e1  = '{last: 1'b1, number: count_q, title_char: 8'h00, kind: KIND_DONE};
        end else begin
          push.cnt = 2'd1;
          push.e0  = '{last: 1'b1, number: count_q, title_char: 8'h00, kind: KIND_DONE};
        end
        phase_d = PH_HUNT;
        fill_d  = '0;
        count_d = '0;
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (fill_q != FILL_W'(PATTERN_LEN)) begin
              fill_d = fill_q + FILL_W'(1);
            end
            if ((fill_q >= FILL_W'(PATTERN_LEN - 1)) && (&cell_match)) begin
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            phase_d = PH_SEEK;
          end
          PH_SEEK: begin
            if (b == CHAR_GT) begin
              phase_d = PH_TITLE;
            end
          end
          PH_TITLE: begin
            push.cnt = 2'd1;
            if (b == CHAR_LT) begin
              push.e0 = '{last: 1'b1, number: num_now, title_char: 8'h00, kind: KIND_END};
              if (count_q != COUNT_MAX) begin
                count_d = count_q + 16'd1;
              end
              phase_d = PH_HUNT;
              fill_d  = '0;
            end else begin
              push.e0 = '{last: 1'b1, number: num_now, title_char: b, kind: KIND_CHAR};
            end
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  // Result queue decouples the output side
  tte_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (res)
  );

  assign m_axis_tdata = {(OUT_DATA_W - RES_DATA_W)'(0), res.number, res.title_char, res.kind};
  assign m_axis_tlast = res.last;

endmodule

/* bench/tagged_title_extractor_core_tb.sv */
// Testbench for the title extractor: text streams in, predicted result stream checked out.
module tagged_title_extractor_core_tb;
  import tte_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_AFTER   = 80;   // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 300;

  // Receiver stall modes
  localparam int unsigned RX_ALWAYS = 0;
  localparam int unsigned RX_RANDOM = 1;
  localparam int unsigned RX_SPARSE = 2;
  localparam int unsigned RX_MOSTLY = 3;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] text_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [2:0] kind, [10:3] title_char, [26:11] result_number
  logic        m_axis_tlast;           // last_of_run

  tagged_title_extractor_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // Predictor state
  logic [7:0]  start_pat  [PATTERN_LEN];
  logic [7:0]  seen_win   [PATTERN_LEN];
  int unsigned win_fill;
  logic [1:0]  scan_phase;
  logic [15:0] titles_done;

  logic [7:0]  text_q [$];   // bytes waiting to be offered
  res_t        want_q [$];   // predicted results, oldest first
  res_t        want_res;

  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned titles_closed = 0;
  int unsigned texts_ended   = 0;
  int unsigned gap_left      = 0;
  int unsigned burst_left    = 1;
  int unsigned rx_mode       = RX_ALWAYS;
  int unsigned rx_cycle      = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic void clear_scan();
    for (int i = 0; i < PATTERN_LEN; i++) seen_win[i] = 8'h00;
    win_fill    = 0;
    scan_phase  = PH_HUNT;
    titles_done = '0;
  endfunction

  function automatic logic [15:0] title_number();
    return (titles_done == COUNT_MAX) ? COUNT_MAX : titles_done + 16'd1;
  endfunction

  function automatic void push_want(input logic [2:0] kind, input logic [7:0] ch,
                                    input logic [15:0] num, input logic last);
    res_t r;
    r.kind       = kind;
    r.title_char = ch;
    r.number     = num;
    r.last       = last;
    want_q.push_back(r);
  endfunction

  // Work out the results one accepted text byte causes
  function automatic void predict_text_byte(input logic [7:0] b);
    bit hit;
    if (b == CHAR_NUL) begin
      if (scan_phase == PH_SKIP || scan_phase == PH_SEEK)
        push_want(KIND_NO_GT, 8'h00, title_number(), 1'b0);
      else if (scan_phase == PH_TITLE)
        push_want(KIND_NO_LT, 8'h00, title_number(), 1'b0);
      push_want(KIND_DONE, 8'h00, titles_done, 1'b1);
      clear_scan();
      texts_ended++;
    end else begin
      case (scan_phase)
        PH_HUNT: begin
          for (int i = 0; i < PATTERN_LEN - 1; i++) seen_win[i] = seen_win[i+1];
          seen_win[PATTERN_LEN-1] = b;
          if (win_fill < PATTERN_LEN) win_fill++;
          hit = (win_fill == PATTERN_LEN);
          for (int i = 0; i < PATTERN_LEN; i++)
            if (seen_win[i] != start_pat[i]) hit = 1'b0;
          if (hit) scan_phase = PH_SKIP;
        end
        PH_SKIP: scan_phase = PH_SEEK;
        PH_SEEK: if (b == CHAR_GT) scan_phase = PH_TITLE;
        default: begin
          if (b == CHAR_LT) begin
            push_want(KIND_END, 8'h00, title_number(), 1'b1);
            if (titles_done != COUNT_MAX) titles_done++;
            scan_phase = PH_HUNT;
            win_fill   = 0;
          end else begin
            push_want(KIND_CHAR, b, title_number(), 1'b1);
          end
        end
      endcase
    end
  endfunction

  // Random non-zero byte, markers favoured, never equal to avoid
  function automatic logic [7:0] rand_text_byte(input logic [7:0] avoid);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? CHAR_GT : CHAR_LT;
      else b = 8'($urandom_range(1, 255));
    end while (b == CHAR_NUL || b == avoid);
    return b;
  endfunction

  task automatic add_noise(input int n, input logic [7:0] avoid);
    for (int i = 0; i < n; i++) text_q.push_back(rand_text_byte(avoid));
  endtask

  task automatic add_pattern(input int n);
    for (int i = 0; i < n; i++) text_q.push_back(start_pat[i]);
  endtask

  // Pattern, skipped byte, junk before '>', then the title
  task automatic add_title(input int len, input bit closed);
    add_pattern(PATTERN_LEN);
    add_noise(1, CHAR_NUL);
    add_noise($urandom_range(0, 3), CHAR_GT);
    text_q.push_back(CHAR_GT);
    add_noise(len, CHAR_LT);
    if (closed) text_q.push_back(CHAR_LT);
  endtask

  task automatic add_random_text();
    int n_titles;
    int ending;
    add_noise($urandom_range(0, 12), CHAR_NUL);
    // near miss: a pattern prefix cut short
    if ($urandom_range(0, 3) == 0) begin
      add_pattern($urandom_range(1, PATTERN_LEN - 1));
      add_noise($urandom_range(1, 4), CHAR_NUL);
    end
    n_titles = $urandom_range(0, 3);
    for (int t = 0; t < n_titles; t++) begin
      add_noise($urandom_range(0, 5), CHAR_NUL);
      add_title(($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12), 1'b1);
    end
    ending = $urandom_range(0, 9);
    case (ending)
      0: add_pattern(PATTERN_LEN);
      1: begin
        add_pattern(PATTERN_LEN);
        add_noise(1, CHAR_NUL);
      end
      2: begin
        add_pattern(PATTERN_LEN);
        add_noise(1 + $urandom_range(0, 4), CHAR_GT);
      end
      3: add_title($urandom_range(1, 8), 1'b0);
      4: add_noise(60, CHAR_NUL);
      default: ;
    endcase
    text_q.push_back(CHAR_NUL);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_text_byte(s_axis_tdata);
        bytes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (text_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= text_q.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall mode re-drawn at random periodically, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(RX_ALWAYS, RX_MOSTLY);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= (rx_cycle % 4 == 0);
          default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result checker: each transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (want_q.size() == 0) begin
        report_mismatch("result with nothing predicted", m_axis_tdata, 0);
      end else begin
        want_res = want_q.pop_front();
        if (want_res.kind == KIND_END) titles_closed++;
        if (m_axis_tdata[2:0] != want_res.kind)
          report_mismatch("kind", m_axis_tdata[2:0], want_res.kind);
        if (m_axis_tdata[10:3] != want_res.title_char)
          report_mismatch("title_char", m_axis_tdata[10:3], want_res.title_char);
        if (m_axis_tdata[26:11] != want_res.number)
          report_mismatch("result_number", m_axis_tdata[26:11], want_res.number);
        if (m_axis_tlast != want_res.last)
          report_mismatch("last_of_run", m_axis_tlast, want_res.last);
        if (m_axis_tdata[31:27] != '0)
          report_mismatch("tdata padding", m_axis_tdata[31:27], 0);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    for (int i = 0; i < PATTERN_LEN; i++)
      start_pat[i] = (i < PATTERN_TEXT_LEN) ?
                     PATTERN_TEXT[(PATTERN_TEXT_LEN - 1 - i) * 8 +: 8] : CHAR_NUL;
    clear_scan();

    // empty text: plain end
    text_q.push_back(CHAR_NUL);
    // extreme byte values, hunting only
    text_q.push_back(8'hFF);
    text_q.push_back(8'h01);
    text_q.push_back(8'h80);
    text_q.push_back(8'h7F);
    text_q.push_back(CHAR_NUL);
    // match right at the end of the text
    add_pattern(PATTERN_LEN);
    text_q.push_back(CHAR_NUL);
    // skipped byte is '>', then the end while seeking
    add_pattern(PATTERN_LEN);
    text_q.push_back(CHAR_GT);
    text_q.push_back(CHAR_NUL);
    // skipped byte is '<', title of extreme bytes, closed, then a second title left open
    add_pattern(PATTERN_LEN);
    text_q.push_back(CHAR_LT);
    text_q.push_back(CHAR_GT);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h01);
    text_q.push_back(CHAR_GT);
    text_q.push_back(CHAR_LT);
    add_pattern(PATTERN_LEN);
    text_q.push_back(8'h41);
    text_q.push_back(CHAR_GT);
    text_q.push_back(8'h42);
    text_q.push_back(CHAR_NUL);

    while (text_q.size() < RANDOM_BYTES - 60) add_random_text();

    rst_ni <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (want_q.size() != 0) report_mismatch("results never delivered", 0, want_q.size());

    $display("Sent %0d text bytes over %0d texts; checked %0d results, %0d closed titles.",
             bytes_sent, texts_ended, results_seen, titles_closed);
    $display("Mismatches: %0d (random stalls, bursts and one long output hold-off).", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Run timed out with %0d results outstanding.", want_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
